>>> src/edma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edma_pkg: shared types and constants of the echo distance averaging unit
// fixed field widths, scaling constants and the inter-stage structs
// ----------------------------------------------------------------------------
package edma_pkg;

  localparam int ECHO_W   = 16;
  localparam int COEF_W   = 10;
  localparam int DIST_W   = 19;

  localparam logic [COEF_W-1:0] COEF_RESET = 10'd171;
  localparam logic [DIST_W-1:0] DIST_MAX   = 19'd524287;

  // width * coef, then * 256 / 10000 = * 16 / 625
  localparam int PROD_W     = ECHO_W + COEF_W;
  localparam int PRE_SHIFT  = 4;
  localparam int SCALED_W   = PROD_W + PRE_SHIFT;
  // floor(x / 625) = (x * ceil(2^40 / 625)) >> 40, exact for x below 2^30
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_W     = 31;
  localparam logic [RECIP_W-1:0] RECIP_625 = 31'd1759218605;
  localparam int MUL_W       = SCALED_W + RECIP_W;
  localparam int QUOT_W      = MUL_W - RECIP_SHIFT;

  typedef struct packed {
    logic              valid;
    logic              timeout;
    logic [QUOT_W-1:0] quot;
  } scale_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] avg;
    logic [DIST_W-1:0] curr;
  } result_t;

endpackage

>>> src/edma_echo_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edma_echo_if: echo width channel
// valid/ready handshake carrying one echo width word
// ----------------------------------------------------------------------------
interface edma_echo_if;
  logic                        valid;
  logic                        ready;
  logic [edma_pkg::ECHO_W-1:0] echo_width_us;

  modport source (output valid, output echo_width_us, input ready);
  modport sink (input valid, input echo_width_us, output ready);
endinterface

>>> src/edma_dist_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edma_dist_if: distance result channel
// valid/ready handshake carrying the window average and current distance
// ----------------------------------------------------------------------------
interface edma_dist_if;
  logic                        valid;
  logic                        ready;
  logic [edma_pkg::DIST_W-1:0] average_distance;
  logic [edma_pkg::DIST_W-1:0] current_distance;

  modport source (output valid, output average_distance, output current_distance,
                  input ready);
  modport sink (input valid, input average_distance, input current_distance,
                output ready);
endinterface

>>> src/edma_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edma_scale: echo width to distance scaling pipeline
// two multiplier stages: width times coefficient, then reciprocal of 625
// ----------------------------------------------------------------------------
module edma_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic                        valid_i,
  input  logic [edma_pkg::ECHO_W-1:0] width_i,
  input  logic [edma_pkg::COEF_W-1:0] coef_i,
  output edma_pkg::scale_t            scale_o
);

  logic                          v1_q;
  logic                          to1_q;
  logic [edma_pkg::PROD_W-1:0]   prod_d, prod_q;
  logic                          v2_q;
  logic                          to2_q;
  logic [edma_pkg::SCALED_W-1:0] scaled;
  logic [edma_pkg::MUL_W-1:0]    recip_prod;
  logic [edma_pkg::QUOT_W-1:0]   quot_d, quot_q;

  assign prod_d = edma_pkg::PROD_W'(width_i) * edma_pkg::PROD_W'(coef_i);

  assign scaled     = {prod_q, {edma_pkg::PRE_SHIFT{1'b0}}};
  assign recip_prod = edma_pkg::MUL_W'(scaled) * edma_pkg::MUL_W'(edma_pkg::RECIP_625);
  assign quot_d     = recip_prod[edma_pkg::MUL_W-1:edma_pkg::RECIP_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (advance_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      prod_q <= prod_d;
      to1_q  <= (width_i == '0);
      quot_q <= quot_d;
      to2_q  <= to1_q;
    end
  end

  assign scale_o.valid   = v2_q;
  assign scale_o.timeout = to2_q;
  assign scale_o.quot    = quot_q;

endmodule

>>> src/edma_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edma_cell: one window entry
// holds a distance and hands it to the next cell on each shift
// ----------------------------------------------------------------------------
module edma_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic [edma_pkg::DIST_W-1:0] dist_i,
  output logic [edma_pkg::DIST_W-1:0] dist_o
);

  logic [edma_pkg::DIST_W-1:0] dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0;
    end else if (shift_i) begin
      dist_q <= dist_i;
    end
  end

  assign dist_o = dist_q;

endmodule

>>> src/edma_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edma_window: timeout hold, chain of window cells and running average
// keeps the running total and divides it by the window length
// ----------------------------------------------------------------------------
module edma_window #(
  parameter int WINDOW_LEN = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  edma_pkg::scale_t   scale_i,
  output edma_pkg::result_t  result_o
);

  localparam int LEN_W     = $clog2(WINDOW_LEN);
  localparam int TOT_W     = edma_pkg::DIST_W + LEN_W;
  localparam int AVG_SHIFT = TOT_W + LEN_W;
  localparam int AVG_RW    = TOT_W + 1;
  localparam int AVG_MW    = TOT_W + AVG_RW;
  localparam logic [63:0] AVG_RECIP =
    ((64'd1 << AVG_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);

  logic [edma_pkg::DIST_W-1:0] sat_dist;
  logic [edma_pkg::DIST_W-1:0] dist_d;
  logic [edma_pkg::DIST_W-1:0] last_q;
  logic                        load;
  logic [edma_pkg::DIST_W-1:0] tap [WINDOW_LEN+1];
  logic [TOT_W-1:0]            total_d, total_q;
  logic                        v3_q;
  logic [edma_pkg::DIST_W-1:0] dist3_q;
  logic [AVG_MW-1:0]           avg_prod;
  logic                        v4_q;
  logic [edma_pkg::DIST_W-1:0] avg4_q;
  logic [edma_pkg::DIST_W-1:0] dist4_q;

  // saturate the scaled distance to 19 bits
  assign sat_dist = (scale_i.quot > edma_pkg::QUOT_W'(edma_pkg::DIST_MAX)) ?
                    edma_pkg::DIST_MAX : scale_i.quot[edma_pkg::DIST_W-1:0];
  assign dist_d   = scale_i.timeout ? last_q : sat_dist;
  assign load     = advance_i & scale_i.valid;

  assign tap[0] = dist_d;
  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    edma_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(load),
      .dist_i (tap[i]),
      .dist_o (tap[i+1])
    );
  end

  // oldest entry drops out of the total as the new one enters
  assign total_d = total_q - TOT_W'(tap[WINDOW_LEN]) + TOT_W'(dist_d);

  assign avg_prod = AVG_MW'(total_q) * AVG_MW'(AVG_RECIP[AVG_RW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      total_q <= '0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
    end else begin
      if (load) begin
        total_q <= total_d;
        if (!scale_i.timeout) begin
          last_q <= sat_dist;
        end
      end
      if (advance_i) begin
        v3_q <= scale_i.valid;
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      dist3_q <= dist_d;
      avg4_q  <= avg_prod[AVG_SHIFT +: edma_pkg::DIST_W];
      dist4_q <= dist3_q;
    end
  end

  assign result_o.valid = v4_q;
  assign result_o.avg   = avg4_q;
  assign result_o.curr  = dist4_q;

endmodule

>>> src/echo_distance_moving_average_unit.sv
`timescale 1ns / 1ps
// throughput: one word per cycle unless dist_o stalls, set by the single-issue
//   pipeline of two multiplier stages, the window update stage and the average stage
// reset: asynchronous active low; the window cells, running total and held
//   distance clear to zero and the coefficient returns to 171
// ----------------------------------------------------------------------------
// echo_distance_moving_average_unit: echo width to averaged distance
// scales each echo width to centimetres (8 fraction bits), holds the last
// distance on a timeout and reports the moving average over the window
// ----------------------------------------------------------------------------
module echo_distance_moving_average_unit #(
  parameter int WINDOW_LEN = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [edma_pkg::COEF_W-1:0] cfg_wdata_i,
  edma_echo_if.sink                   echo_i,
  edma_dist_if.source                 dist_o
);

  // half sound speed coefficient; the user must write it only while the unit is idle, the block does not enforce it
  logic [edma_pkg::COEF_W-1:0] coef_q;
  // the whole pipeline moves when the output register is free or drained
  logic                        advance;
  edma_pkg::scale_t            scale;
  edma_pkg::result_t           result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= edma_pkg::COEF_RESET;
    end else if (cfg_we_i) begin
      coef_q <= cfg_wdata_i;
    end
  end

  assign advance      = !result.valid || dist_o.ready;
  assign echo_i.ready = advance;

  // stages one and two: product, then exact divide by 625 via reciprocal
  edma_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .valid_i  (echo_i.valid),
    .width_i  (echo_i.echo_width_us),
    .coef_i   (coef_q),
    .scale_o  (scale)
  );

  // stages three and four: window cell chain update, then average
  edma_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .scale_i  (scale),
    .result_o (result)
  );

  assign dist_o.valid            = result.valid;
  assign dist_o.average_distance = result.avg;
  assign dist_o.current_distance = result.curr;

endmodule

>>> src/edma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edma_checker: port-level checks of the echo distance averaging unit
// watches both channels over time; attached to the top level by bind
// ----------------------------------------------------------------------------
module edma_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [edma_pkg::DIST_W-1:0] out_avg_i,
  input logic [edma_pkg::DIST_W-1:0] out_dist_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_avg_i) && $stable(out_dist_i))
    else $error("result word changed while stalled");

  // an empty output stage never blocks the input
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with output stage empty");

  // a word accepted into a free-running pipeline shows up once it has passed every stage
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_i)
    else $error("result word missing after pipeline latency");

endmodule

bind echo_distance_moving_average_unit edma_checker u_edma_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (echo_i.valid),
  .in_ready_i (echo_i.ready),
  .out_valid_i(dist_o.valid),
  .out_ready_i(dist_o.ready),
  .out_avg_i  (dist_o.average_distance),
  .out_dist_i (dist_o.current_distance)
);

>>> dv/echo_distance_moving_average_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_distance_moving_average_unit_test: self-checking bench for the unit
// drives echo widths through a queue-fed driver with random gaps, predicts the
// distance and window average of every accepted word, and checks each result
// word field by field while the receiver stalls at random or holds off
// ----------------------------------------------------------------------------
module echo_distance_moving_average_unit_test;

  localparam int WINDOW_LEN   = 16;
  localparam int SUM_W        = edma_pkg::DIST_W + $clog2(WINDOW_LEN);
  localparam int DRAIN_CYCLES = 10;       // extra wait beyond the pipeline latency
  localparam int CYCLE_LIMIT  = 200000;   // slowest correct run is far below this
  localparam int HOLD_OFF_LEN = 80;       // long enough to back up the pipeline
  localparam int PRINT_CAP    = 40;

  // one result word as the predictor expects it
  typedef struct packed {
    logic [edma_pkg::DIST_W-1:0] average;
    logic [edma_pkg::DIST_W-1:0] current;
  } distance_word_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [edma_pkg::COEF_W-1:0] cfg_wdata_i;

  edma_echo_if echo_if ();
  edma_dist_if dist_if ();

  echo_distance_moving_average_unit #(
    .WINDOW_LEN(WINDOW_LEN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .echo_i     (echo_if),
    .dist_o     (dist_if)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // stimulus and expectation queues
  logic [edma_pkg::ECHO_W-1:0] pending_widths[$];
  distance_word_t              expected_words[$];

  // idling knobs; the two percentages change only while the unit is idle
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_left  = 0;

  // private copy of the unit's state
  logic [edma_pkg::COEF_W-1:0] coef_copy = edma_pkg::COEF_RESET;
  logic [edma_pkg::DIST_W-1:0] window_cells[WINDOW_LEN];
  logic [SUM_W-1:0]            window_sum = '0;
  int unsigned                 next_cell = 0;
  logic [edma_pkg::DIST_W-1:0] held_distance = '0;

  // run statistics
  int unsigned mismatches    = 0;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned timeouts_sent = 0;
  int unsigned saturated     = 0;
  int unsigned coef_writes   = 0;
  int unsigned cycle_count   = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch: %s", msg);
    end
    mismatches++;
  endtask

  // width * coefficient * 256 / 10000, truncated, clipped to the 19-bit range
  function automatic logic [edma_pkg::DIST_W-1:0] echo_to_distance(
      input logic [edma_pkg::ECHO_W-1:0] width,
      input logic [edma_pkg::COEF_W-1:0] coef);
    logic [63:0] scaled;
    scaled = width;
    scaled = scaled * coef;
    scaled = (scaled << 8) / 64'd10000;
    if (scaled > edma_pkg::DIST_MAX) begin
      saturated++;
      return edma_pkg::DIST_MAX;
    end
    return scaled[edma_pkg::DIST_W-1:0];
  endfunction

  // update the window with one accepted echo word and queue its result word
  function automatic void predict_window_average(input logic [edma_pkg::ECHO_W-1:0] width);
    logic [edma_pkg::DIST_W-1:0] distance;
    distance_word_t              want;
    if (width == '0) begin
      // timeout: the last good distance enters the window again
      distance = held_distance;
      timeouts_sent++;
    end else begin
      distance      = echo_to_distance(width, coef_copy);
      held_distance = distance;
    end
    window_sum                = window_sum - window_cells[next_cell] + distance;
    window_cells[next_cell]   = distance;
    next_cell                 = (next_cell + 1) % WINDOW_LEN;
    want.average              = edma_pkg::DIST_W'(window_sum / WINDOW_LEN);
    want.current              = distance;
    expected_words.push_back(want);
  endfunction

  // mostly plausible ranges, with timeouts, both extremes and full-range noise
  function automatic logic [edma_pkg::ECHO_W-1:0] random_echo_width();
    case ($urandom_range(9))
      0, 1: return '0;
      2, 3: return edma_pkg::ECHO_W'($urandom_range(65535));
      4: return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0001;
      default: return edma_pkg::ECHO_W'($urandom_range(25000, 100));
    endcase
  endfunction

  // echo driver: holds a word until it is taken, then pops the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      echo_if.valid <= 1'b0;
    end else if (!echo_if.valid || echo_if.ready) begin
      if (pending_widths.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        echo_if.valid         <= 1'b1;
        echo_if.echo_width_us <= pending_widths.pop_front();
      end else begin
        echo_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, or nothing at all while a hold-off runs
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      dist_if.ready <= 1'b0;
    end else begin
      dist_if.ready <= (hold_off_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hold-off countdown in a process of its own
  always @(posedge clk_i) begin
    if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end
  end

  // monitor: check the result word first, then predict for the word accepted now;
  // a result always trails its echo word, so this order is safe
  always @(posedge clk_i) begin
    distance_word_t want;
    if (rst_ni) begin
      if (dist_if.valid && dist_if.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected result word avg %0d dist %0d",
                                    dist_if.average_distance, dist_if.current_distance));
        end else begin
          want = expected_words.pop_front();
          if (dist_if.average_distance !== want.average) begin
            report_mismatch($sformatf("word %0d average_distance got %0d expected %0d",
                                      words_checked, dist_if.average_distance,
                                      want.average));
          end
          if (dist_if.current_distance !== want.current) begin
            report_mismatch($sformatf("word %0d current_distance got %0d expected %0d",
                                      words_checked, dist_if.current_distance,
                                      want.current));
          end
        end
        words_checked++;
      end
      if (echo_if.valid && echo_if.ready) begin
        predict_window_average(echo_if.echo_width_us);
        words_sent++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_words.size());
      $display("FAIL echo_distance_moving_average_unit");
      $finish;
    end
  end

  // coefficient writes happen only while nothing is in flight
  task automatic write_coefficient(input logic [edma_pkg::COEF_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    coef_copy    = value;
    coef_writes++;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait until every queued word has gone through and its result has come back
  task automatic drain_unit();
    while (pending_widths.size() != 0 || echo_if.valid || expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic queue_random_widths(input int unsigned count);
    repeat (count) pending_widths.push_back(random_echo_width());
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin
    foreach (window_cells[i]) window_cells[i] = '0;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = '0;
    echo_if.valid         = 1'b0;
    echo_if.echo_width_us = '0;
    dist_if.ready         = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset coefficient, no idling: timeout before any echo, extremes, bit
    // patterns, rounding near one centimetre and a full window wrap
    set_idling(0, 0);
    pending_widths = '{16'd0, 16'd1, 16'd2, 16'd58, 16'd0, 16'd0, 16'hFFFF, 16'h5555,
                       16'hAAAA, 16'h00FF, 16'hFF00, 16'd1000, 16'd0, 16'd30000,
                       16'd12345, 16'hFFFE, 16'h8000, 16'h7FFF, 16'd0, 16'd580};
    drain_unit();

    // largest coefficient: saturation edge, held saturated value; sender gaps
    write_coefficient(10'd1023);
    set_idling(48, 0);
    pending_widths = '{16'hFFFF, 16'd20019, 16'd20020, 16'd0, 16'd1};
    queue_random_widths(60);
    drain_unit();

    // zero coefficient: every good echo gives zero, a timeout still holds the
    // last distance from before; receiver stalls
    write_coefficient(10'd0);
    set_idling(0, 48);
    pending_widths = '{16'd0, 16'hFFFF, 16'd1, 16'd0};
    queue_random_widths(50);
    drain_unit();

    // back to the nominal coefficient, both sides idle
    write_coefficient(edma_pkg::COEF_RESET);
    set_idling(37, 37);
    queue_random_widths(150);
    drain_unit();

    // back-pressure: the receiver holds off while the sender keeps offering
    write_coefficient(edma_pkg::COEF_W'($urandom_range(1022, 1)));
    set_idling(0, 0);
    queue_random_widths(120);
    @(posedge clk_i);
    hold_off_left <= HOLD_OFF_LEN;
    drain_unit();

    // smallest non-zero coefficient, full rate
    write_coefficient(10'd1);
    set_idling(0, 0);
    queue_random_widths(60);
    drain_unit();

    // nominal again with sender gaps
    write_coefficient(edma_pkg::COEF_RESET);
    set_idling(48, 0);
    queue_random_widths(100);
    drain_unit();

    $display("covered %0d echo words (%0d timeouts, %0d saturated) over %0d coefficient writes",
             words_sent, timeouts_sent, saturated, coef_writes);
    $display("checked %0d result words, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS echo_distance_moving_average_unit");
    end else begin
      $display("FAIL echo_distance_moving_average_unit");
    end
    $finish;
  end

endmodule
